[hw/rtl/pipc_pkg.sv]
package pipc_pkg;

   // Field and arithmetic widths.
   localparam int COORD_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int CORNER_W = COORD_W + 2;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = CORNER_W + DIFF_W;
   localparam int DET_W    = PROD_W + 1;

   // One unit in Q16.16, used to push the far corner past the bounding box.
   localparam logic signed [CORNER_W-1:0] Q_ONE = CORNER_W'(65536);

   // Operation codes of an input word.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Product pair selected for the shared multipliers.
   localparam int MUL_SEL_W = 2;
   localparam logic [MUL_SEL_W-1:0] MUL_DEN = 2'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_NT  = 2'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_NU  = 2'd2;

   typedef struct packed {
      logic                      operation;
      logic [INDEX_W-1:0]        vertex_index;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_word_type;

   typedef struct packed {
      logic               inside_res;
      logic [COUNT_W-1:0] crossing_count;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 start;
      logic                 load_wr;
      logic                 rd_en;
      logic                 max_rd;
      logic                 corner;
      logic                 take_first;
      logic                 edge_load;
      logic                 edge_close;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic                 den_en;
      logic                 nt_en;
      logic                 nu_en;
      logic                 count_en;
      logic                 result_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;
      logic idx_end;
      logic rd_last;
   } status_type;

endpackage

[hw/rtl/pipc_ram.sv]
module pipc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pipc_ctrl.sv]
module pipc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pipc_pkg::status_type status,
   output pipc_pkg::cmd_type    cmd
);

   import pipc_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_MAX    = 4'd2;
   localparam logic [3:0] S_MAXW   = 4'd3;
   localparam logic [3:0] S_CORNER = 4'd4;
   localparam logic [3:0] S_RD0    = 4'd5;
   localparam logic [3:0] S_FIRST  = 4'd6;
   localparam logic [3:0] S_RD     = 4'd7;
   localparam logic [3:0] S_EDGE   = 4'd8;
   localparam logic [3:0] S_CLOSE  = 4'd9;
   localparam logic [3:0] S_M0     = 4'd10;
   localparam logic [3:0] S_M1     = 4'd11;
   localparam logic [3:0] S_M2     = 4'd12;
   localparam logic [3:0] S_M3     = 4'd13;
   localparam logic [3:0] S_CHK    = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       closing_ff, closing_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands for each step of a query.
   always_comb begin
      state_in   = state_ff;
      closing_in = closing_ff;
      cmd        = '0;
      cmd.mul_sel = MUL_DEN;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_QUERY) begin
                  cmd.start  = 1'b1;
                  closing_in = 1'b0;
                  state_in   = S_START;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_START: begin
            state_in = status.n_zero ? S_DONE : S_MAX;
         end
         S_MAX: begin
            cmd.rd_en  = 1'b1;
            cmd.max_rd = 1'b1;
            if (status.rd_last) begin
               state_in = S_MAXW;
            end
         end
         S_MAXW: begin
            state_in = S_CORNER;
         end
         S_CORNER: begin
            cmd.corner = 1'b1;
            state_in   = S_RD0;
         end
         S_RD0: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FIRST;
         end
         S_FIRST: begin
            cmd.take_first = 1'b1;
            state_in       = status.idx_end ? S_CLOSE : S_RD;
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EDGE;
         end
         S_EDGE: begin
            cmd.edge_load = 1'b1;
            state_in      = S_M0;
         end
         S_CLOSE: begin
            cmd.edge_load  = 1'b1;
            cmd.edge_close = 1'b1;
            closing_in     = 1'b1;
            state_in       = S_M0;
         end
         S_M0: begin
            cmd.mul_sel = MUL_DEN;
            state_in    = S_M1;
         end
         S_M1: begin
            cmd.den_en  = 1'b1;
            cmd.mul_sel = MUL_NT;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.nt_en   = 1'b1;
            cmd.mul_sel = MUL_NU;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.nu_en = 1'b1;
            state_in  = S_CHK;
         end
         S_CHK: begin
            cmd.count_en = 1'b1;
            if (closing_ff) begin
               state_in = S_DONE;
            end else if (status.idx_end) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result word stays valid until it is taken.
   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         closing_ff   <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/pipc_dpath.sv]
module pipc_dpath #(
   parameter int MAX_VERTICES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pipc_pkg::cmd_type                   cmd,
   input  pipc_pkg::req_word_type              req_word,
   input  logic [pipc_pkg::COUNT_W-1:0]        vertex_count,
   output pipc_pkg::status_type                status,
   output pipc_pkg::rsp_word_type              rsp_word
);

   import pipc_pkg::*;

   localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
   localparam int SLOT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int WORD_W = 2 * COORD_W;

   // Is v within [0, d] after normalizing the sign of d?
   function automatic logic within_den(input logic signed [DET_W-1:0] v,
                                       input logic signed [DET_W-1:0] d);
      logic nonpos;
      logic nonneg;
      nonpos = v[DET_W-1] || (v == '0);
      nonneg = !v[DET_W-1];
      if (d[DET_W-1]) begin
         return nonpos && (v >= d);
      end
      return nonneg && (v <= d);
   endfunction

   logic signed [COORD_W-1:0]  px_ff, py_ff;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [CNT_W-1:0]           idx_ff;
   logic                       max_pend_ff;
   logic signed [COORD_W-1:0]  mx_ff, my_ff;
   logic signed [CORNER_W-1:0] abx_ff, aby_ff;
   logic signed [CORNER_W-1:0] ox, oy;
   logic signed [COORD_W-1:0]  first_x_ff, first_y_ff;
   logic signed [COORD_W-1:0]  prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0]  dx, dy;
   logic signed [DIFF_W-1:0]   cdx_ff, cdy_ff, cax_ff, cay_ff;
   logic signed [CORNER_W-1:0] mul_a0, mul_a1;
   logic signed [DIFF_W-1:0]   mul_b0, mul_b1;
   logic signed [PROD_W-1:0]   p0_ff, p1_ff;
   logic signed [DET_W-1:0]    det;
   logic signed [DET_W-1:0]    den_ff, nt_ff, nu_ff;
   logic                       hit;
   logic [COUNT_W-1:0]         hits_ff;
   rsp_word_type               rsp_ff;

   logic [SLOT_W-1:0]          slot_ext;
   logic                       ram_wr_en;
   logic [WORD_W-1:0]          ram_rd_data;
   logic signed [COORD_W-1:0]  vx, vy;

   // Vertex table, x in the upper half of each word.
   assign slot_ext  = SLOT_W'(req_word.vertex_index);
   assign ram_wr_en = cmd.load_wr && (32'(req_word.vertex_index) < 32'(MAX_VERTICES));

   pipc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_VERTICES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(slot_ext[IDX_W-1:0]),
      .wr_data({req_word.point_x, req_word.point_y}),
      .rd_en  (cmd.rd_en),
      .rd_addr(idx_ff[IDX_W-1:0]),
      .rd_data(ram_rd_data)
   );

   assign vx = ram_rd_data[WORD_W-1:COORD_W];
   assign vy = ram_rd_data[COORD_W-1:0];

   // Vertices in use, limited to the table size.
   assign n_in = (32'(vertex_count) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : CNT_W'(vertex_count);

   assign status.n_zero  = (n_ff == '0);
   assign status.idx_end = (idx_ff == n_ff);
   assign status.rd_last = ((idx_ff + CNT_W'(1)) == n_ff);

   // Query point, vertex count and read index.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= req_word.point_x;
         py_ff <= req_word.point_y;
         n_ff  <= n_in;
      end
      if (cmd.start || cmd.corner) begin
         idx_ff <= '0;
      end else if (cmd.rd_en) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   // Bounding pass: max_pend_ff is max_rd registered, in step with the registered read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_pend_ff <= 1'b0;
      end else begin
         max_pend_ff <= cmd.max_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mx_ff <= {1'b1, {(COORD_W-1){1'b0}}};
         my_ff <= {1'b1, {(COORD_W-1){1'b0}}};
      end else if (max_pend_ff) begin
         if (vx > mx_ff) begin
            mx_ff <= vx;
         end
         if (vy > my_ff) begin
            my_ff <= vy;
         end
      end
   end

   // Ray direction from the query point to the far corner.
   assign ox = CORNER_W'(mx_ff) + Q_ONE;
   assign oy = CORNER_W'(my_ff) + Q_ONE;

   always_ff @(posedge clock) begin
      if (cmd.corner) begin
         abx_ff <= ox - CORNER_W'(px_ff);
         aby_ff <= oy - CORNER_W'(py_ff);
      end
   end

   // Edge endpoints: previous vertex to the one just read, or back to the first.
   assign dx = cmd.edge_close ? first_x_ff : vx;
   assign dy = cmd.edge_close ? first_y_ff : vy;

   always_ff @(posedge clock) begin
      if (cmd.take_first) begin
         first_x_ff <= vx;
         first_y_ff <= vy;
         prev_x_ff  <= vx;
         prev_y_ff  <= vy;
      end else if (cmd.edge_load && !cmd.edge_close) begin
         prev_x_ff <= vx;
         prev_y_ff <= vy;
      end
      if (cmd.edge_load) begin
         cdx_ff <= DIFF_W'(dx) - DIFF_W'(prev_x_ff);
         cdy_ff <= DIFF_W'(dy) - DIFF_W'(prev_y_ff);
         cax_ff <= DIFF_W'(prev_x_ff) - DIFF_W'(px_ff);
         cay_ff <= DIFF_W'(prev_y_ff) - DIFF_W'(py_ff);
      end
   end

   // Two shared multipliers, one product pair per cycle.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_NT: begin
            mul_a0 = CORNER_W'(cax_ff);
            mul_b0 = cdy_ff;
            mul_a1 = CORNER_W'(cay_ff);
            mul_b1 = cdx_ff;
         end
         MUL_NU: begin
            mul_a0 = aby_ff;
            mul_b0 = cax_ff;
            mul_a1 = abx_ff;
            mul_b1 = cay_ff;
         end
         default: begin
            mul_a0 = abx_ff;
            mul_b0 = cdy_ff;
            mul_a1 = aby_ff;
            mul_b1 = cdx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p0_ff <= mul_a0 * mul_b0;
      p1_ff <= mul_a1 * mul_b1;
   end

   // Determinants from the registered product pair.
   assign det = DET_W'(p0_ff) - DET_W'(p1_ff);

   always_ff @(posedge clock) begin
      if (cmd.den_en) begin
         den_ff <= det;
      end
      if (cmd.nt_en) begin
         nt_ff <= det;
      end
      if (cmd.nu_en) begin
         nu_ff <= det;
      end
   end

   // A parallel edge never counts; endpoints do.
   assign hit = (den_ff != '0) && within_den(nt_ff, den_ff) && within_den(nu_ff, den_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hits_ff <= '0;
      end else if (cmd.count_en && hit) begin
         hits_ff <= hits_ff + COUNT_W'(1);
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ff.inside_res     <= hits_ff[0];
         rsp_ff.crossing_count <= hits_ff;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

[hw/rtl/point_in_polygon_ray_crossing.sv]
// Channel   Ports                                      Direction  Word
// input     req_valid, req_ready, req_word             in         load vertex or query point
// result    rsp_valid, rsp_ready, rsp_word             out        inside flag, crossing count
// config    csr_write_en, csr_write_data               in         vertex count
//
// A load word is written straight from the idle state. A query over n vertices makes
// one table read per vertex for the bounding pass, then steps through each edge in
// turn, paced by the two shared multipliers that form three product pairs per edge
// and by the single table read port. A query with n of zero goes straight to its result.
// Reset clears the controller, the result valid and the vertex count; the table
// holds no reset value. A stalled result word blocks only the next query's end.
module point_in_polygon_ray_crossing #(
   parameter int MAX_VERTICES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pipc_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pipc_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_write_en,
   input  logic [pipc_pkg::COUNT_W-1:0]   csr_write_data
);

   import pipc_pkg::*;

   logic [COUNT_W-1:0] vertex_count_ff;
   cmd_type            cmd;
   status_type         status;

   // Vertex count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else if (csr_write_en) begin
         vertex_count_ff <= csr_write_data;
      end
   end

   pipc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_word.operation),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .cmd          (cmd)
   );

   pipc_dpath #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_word    (req_word),
      .vertex_count(vertex_count_ff),
      .status      (status),
      .rsp_word    (rsp_word)
   );

endmodule

[tb/sv/testbench.sv]
module testbench;
   import pipc_pkg::*;

   localparam int MAX_VERTICES = 256;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 32;
   localparam int DRAIN_CYCLES = 64;
   localparam int PRINT_CAP = 100;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

   typedef logic signed [127:0] prod_type;
   typedef enum {ROW_CFG, ROW_WORD} row_kind_type;
   typedef struct {
      row_kind_type       kind;
      logic [COUNT_W-1:0] count;
      req_word_type       word;
      bit                 typed;
      rsp_word_type       want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write_en = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   // Shadow of the vertex table and of the vertex count register.
   longint poly_x [MAX_VERTICES];
   longint poly_y [MAX_VERTICES];
   logic [COUNT_W-1:0] model_count = '0;

   rsp_word_type pending_rsp [$];
   stim_row_type dir_rows [$];

   int cycle_count = 0;
   int errors = 0;
   int items_sent = 0;
   int loads_done = 0;
   int queries_done = 0;
   int count_writes = 0;
   int results_seen = 0;
   int inside_seen = 0;
   int max_crossings = 0;
   int rounds_done = 0;
   bit calm = 1'b0;

   point_in_polygon_ray_crossing #(
      .MAX_VERTICES(MAX_VERTICES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact segment test: endpoints count, parallel and degenerate edges do not.
   function automatic bit segments_meet(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy);
      longint abx, aby, cdx, cdy, cax, cay;
      prod_type den, nt, nu;
      abx = bx - ax;
      aby = by - ay;
      cdx = dx - cx;
      cdy = dy - cy;
      cax = cx - ax;
      cay = cy - ay;
      den = prod_type'(abx) * prod_type'(cdy) - prod_type'(aby) * prod_type'(cdx);
      if (den == 0) return 1'b0;
      nt = prod_type'(cax) * prod_type'(cdy) - prod_type'(cay) * prod_type'(cdx);
      nu = prod_type'(cax) * prod_type'(aby) - prod_type'(cay) * prod_type'(abx);
      if (den < 0) begin
         den = -den;
         nt = -nt;
         nu = -nu;
      end
      return (nt >= 0) && (nt <= den) && (nu >= 0) && (nu <= den);
   endfunction

   // Crossing count of the ray from the query point to the far corner.
   function automatic rsp_word_type predict_crossings(longint px, longint py);
      int n, hits, i, j;
      longint mx, my, ox, oy;
      rsp_word_type r;
      n = (model_count > MAX_VERTICES) ? MAX_VERTICES : int'(model_count);
      hits = 0;
      if (n > 0) begin
         mx = poly_x[0];
         my = poly_y[0];
         for (i = 1; i < n; i++) begin
            if (poly_x[i] > mx) mx = poly_x[i];
            if (poly_y[i] > my) my = poly_y[i];
         end
         ox = mx + longint'(Q_ONE);
         oy = my + longint'(Q_ONE);
         for (i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (segments_meet(px, py, ox, oy, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
               hits++;
         end
      end
      r.inside_res = hits[0];
      r.crossing_count = hits[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] fx(int units);
      return units * 65536;
   endfunction

   function automatic req_word_type make_word(logic op, int idx, logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y);
      req_word_type w;
      w.operation = op;
      w.vertex_index = idx[INDEX_W-1:0];
      w.point_x = x;
      w.point_y = y;
      return w;
   endfunction

   function automatic stim_row_type cfg_row(int v);
      stim_row_type r;
      r = '{ROW_CFG, v[COUNT_W-1:0], '0, 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type load_row(int idx, logic signed [COORD_W-1:0] x,
                                             logic signed [COORD_W-1:0] y);
      stim_row_type r;
      r = '{ROW_WORD, '0, make_word(OP_LOAD, idx, x, y), 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type query_row(int idx, logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y);
      stim_row_type r;
      r = '{ROW_WORD, '0, make_word(OP_QUERY, idx, x, y), 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type known_row(logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y, int count);
      stim_row_type r;
      r = '{ROW_WORD, '0, make_word(OP_QUERY, 0, x, y), 1'b1, '0};
      r.want.inside_res = count[0];
      r.want.crossing_count = count[COUNT_W-1:0];
      return r;
   endfunction

   // Adds one row at the end of the directed table.
   function automatic void append_row(stim_row_type r);
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(int scale);
      int v;
      case (scale)
         0: begin
            v = $urandom_range(0, 16);
            return fx(v - 8);
         end
         1: begin
            v = $urandom_range(0, 2097152);
            return v - 1048576;
         end
         2: return $urandom;
         default: begin
            v = $urandom_range(0, 4);
            return fx(v);
         end
      endcase
   endfunction

   function automatic longint pick_between(longint lo, longint hi);
      longint unsigned span;
      span = longint'(hi - lo) + 1;
      return lo + longint'({$urandom, $urandom} % span);
   endfunction

   task automatic note_mismatch(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // Present one word, hold it until accepted, then update the shadow state.
   task automatic send_word(req_word_type w, bit typed, rsp_word_type want);
      calm = (items_sent >= 300) && (items_sent < 450);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (w.operation == OP_LOAD) begin
         poly_x[w.vertex_index] = w.point_x;
         poly_y[w.vertex_index] = w.point_y;
         loads_done++;
      end else begin
         pending_rsp.insert(pending_rsp.size(),
                            typed ? want : predict_crossings(w.point_x, w.point_y));
         queries_done++;
      end
   endtask

   task automatic send_load(int idx, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
      send_word(make_word(OP_LOAD, idx, x, y), 1'b0, '0);
   endtask

   // The count register is only written once the block has gone quiet.
   task automatic write_vertex_count(logic [COUNT_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      model_count = v;
      count_writes++;
   endtask

   // Query points: mostly inside or near the bounding box, some on vertices or grid.
   task automatic send_random_query();
      int n_eff, mode, v, i;
      longint lo_x, hi_x, lo_y, hi_y;
      logic signed [COORD_W-1:0] qx, qy;
      n_eff = (model_count > MAX_VERTICES) ? MAX_VERTICES : int'(model_count);
      mode = $urandom_range(0, 99);
      if (n_eff == 0 || mode < 12) begin
         qx = $urandom;
         qy = $urandom;
      end else if (mode < 27) begin
         v = $urandom_range(0, n_eff - 1);
         qx = COORD_W'(poly_x[v]);
         qy = COORD_W'(poly_y[v]);
      end else if (mode < 40) begin
         v = $urandom_range(0, 18);
         qx = fx(v - 9);
         v = $urandom_range(0, 18);
         qy = fx(v - 9);
      end else begin
         lo_x = poly_x[0];
         hi_x = poly_x[0];
         lo_y = poly_y[0];
         hi_y = poly_y[0];
         for (i = 1; i < n_eff; i++) begin
            if (poly_x[i] < lo_x) lo_x = poly_x[i];
            if (poly_x[i] > hi_x) hi_x = poly_x[i];
            if (poly_y[i] < lo_y) lo_y = poly_y[i];
            if (poly_y[i] > hi_y) hi_y = poly_y[i];
         end
         qx = COORD_W'(pick_between(lo_x - 65536, hi_x + 65536));
         qy = COORD_W'(pick_between(lo_y - 65536, hi_y + 65536));
      end
      send_word(make_word(OP_QUERY, $urandom_range(0, 255), qx, qy), 1'b0, '0);
   endtask

   // One polygon: load its vertices in shuffled order, set the count, then query.
   // A few rounds only rewrite some slots and keep the old count.
   task automatic run_random_round();
      int n, scale, pick, k, i, j, tmp;
      int order [$];
      bit keep_count;
      keep_count = (rounds_done > 0) && ($urandom_range(0, 9) == 0);
      scale = $urandom_range(0, 3);
      if (keep_count) begin
         k = $urandom_range(1, 4);
         for (i = 0; i < k; i++) send_load($urandom_range(0, 255), rand_coord(scale),
                                           rand_coord(scale));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 8) n = $urandom_range(0, 2);
         else if (pick < 90) n = $urandom_range(3, 12);
         else n = $urandom_range(13, 48);
         for (i = 0; i < n; i++) order.insert(order.size(), i);
         for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_load($urandom_range(0, 255), rand_coord(2), rand_coord(2));
            send_load(order[i], rand_coord(scale), rand_coord(scale));
         end
         write_vertex_count(COUNT_W'(n));
      end
      k = $urandom_range(1, 6);
      for (i = 0; i < k; i++) begin
         if (model_count != 0 && $urandom_range(0, 99) < 15)
            send_load($urandom_range(0, model_count - 1), rand_coord(scale), rand_coord(scale));
         send_random_query();
      end
      rounds_done++;
   endtask

   // Fill the whole table and run the largest counts, including one above the table size.
   task automatic run_full_table();
      int i, scale;
      scale = $urandom_range(0, 1) ? 0 : 3;
      for (i = MAX_VERTICES - 1; i >= 0; i--) send_load(i, rand_coord(scale), rand_coord(scale));
      write_vertex_count(COUNT_W'(MAX_VERTICES));
      send_random_query();
      send_random_query();
      write_vertex_count({COUNT_W{1'b1}});
      send_random_query();
      send_random_query();
      write_vertex_count(COUNT_W'(MAX_VERTICES - 1));
      send_random_query();
      write_vertex_count(COUNT_W'(0));
      send_random_query();
   endtask

   // Result side: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_word.inside_res) inside_seen++;
            if (int'(rsp_word.crossing_count) > max_crossings)
               max_crossings = int'(rsp_word.crossing_count);
            if (pending_rsp.size() == 0) begin
               note_mismatch("result word with no query outstanding");
            end else begin
               if (rsp_word.inside_res !== pending_rsp[0].inside_res)
                  note_mismatch($sformatf("inside_res got %0b wanted %0b",
                                          rsp_word.inside_res, pending_rsp[0].inside_res));
               if (rsp_word.crossing_count !== pending_rsp[0].crossing_count)
                  note_mismatch($sformatf("crossing_count got %0d wanted %0d",
                                          rsp_word.crossing_count,
                                          pending_rsp[0].crossing_count));
               void'(pending_rsp.pop_front());
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 11);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      // Square (0,0) (4,0) (4,4) (0,4) in slots 0..3; smaller counts reuse its slots.
      append_row(known_row(fx(1), fx(1), 0));
      append_row(load_row(0, fx(0), fx(0)));
      append_row(load_row(1, fx(4), fx(0)));
      append_row(load_row(2, fx(4), fx(4)));
      append_row(load_row(3, fx(0), fx(4)));
      // One vertex: its only edge has zero length.
      append_row(cfg_row(1));
      append_row(known_row(fx(2), fx(2), 0));
      // Two vertices: the same edge twice, both crossed.
      append_row(cfg_row(2));
      append_row(query_row(0, fx(2), -fx(1)));
      // Full square: inside, outside, on a vertex, on an edge, at the far corner.
      append_row(cfg_row(4));
      append_row(query_row(0, fx(2), fx(2)));
      append_row(query_row(0, -fx(1), fx(2)));
      append_row(query_row(0, fx(0), fx(0)));
      append_row(query_row(0, fx(2), fx(0)));
      append_row(known_row(fx(5), fx(5), 0));
      // Triangle whose hypotenuse lies on the ray: the collinear edge is skipped.
      append_row(cfg_row(3));
      append_row(query_row(255, -fx(1), -fx(1)));
      append_row(query_row(0, fx(3), fx(1)));
      // Coordinate extremes; the far corner goes past the 32-bit range.
      append_row(load_row(0, COORD_MAX, COORD_MAX));
      append_row(load_row(1, COORD_MIN, COORD_MIN));
      append_row(load_row(2, COORD_MIN, COORD_MAX));
      append_row(query_row(0, fx(0), fx(0)));
      append_row(query_row(255, COORD_MIN, COORD_MAX));
      append_row(query_row(0, COORD_MAX, COORD_MIN));
      append_row(load_row(255, COORD_MAX, COORD_MIN));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CFG) write_vertex_count(dir_rows[r].count);
         else send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
      end

      while (items_sent < 650) run_random_round();
      run_full_table();

      // Drain the result queue, then let the block settle.
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d vertex loads and %0d queries across %0d count settings, %0d rounds",
               loads_done, queries_done, count_writes, rounds_done);
      $display("checked %0d results, %0d inside, largest crossing count %0d, %0d mismatches",
               results_seen, inside_seen, max_crossings, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
